// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// implication or plain property, checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");
// a condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk_s, rst_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`endif

`endif

// File: rtl/edh_pkg.sv
// ----------------------------------------------------------------------------
// edh_pkg
// constants and register codes of the error diffusion halftoning block
// ----------------------------------------------------------------------------
package edh_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = COL_W + 1;
  localparam int HGT_W = ROW_W + 1;
  localparam int PIX_W = 8;

  // error words and intermediate widths
  localparam int ERR_W   = FRAC_BITS + 10;
  localparam int W_SHIFT = 8;
  localparam int SUM_W   = ERR_W + 10;
  localparam int T_W     = ERR_W + 3;

  localparam int W_ABOVE = 154;
  localparam int W_DIAG  = 26;
  localparam int W_LEFT  = 51;
  localparam int W_ROUND = 1 << (W_SHIFT - 1);

  localparam int ERR_MAX = (1 << (ERR_W - 1)) - 1;
  localparam int ERR_MIN = -(1 << (ERR_W - 1));

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_ONE_VALUE = 3'd1,
    REG_ZERO_VALUE = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_HEIGHT    = 3'd4
  } reg_idx_t;

  localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd127;
  localparam logic [PIX_W-1:0] ONE_VALUE_RST = 8'd255;
  localparam logic [PIX_W-1:0] ZERO_VALUE_RST = 8'd0;
  localparam logic [WID_W-1:0] WIDTH_RST = WID_W'(512);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(512);

endpackage

// File: rtl/error_diffusion_halftone_top.sv
// ----------------------------------------------------------------------------
// error_diffusion_halftone_top
// pipeline: a taken pixel word is registered in stage 1, its result word in the result register
// throughput: one pixel per cycle while out_ready is high, set by the single error feedback stage
// the line memory is read on acceptance, written when the stage completes
// reset: synchronous, clears counters, left/above errors and registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module error_diffusion_halftone_top (
  input  logic                            clk,
  input  logic                            rst,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [edh_pkg::PIX_W-1:0]       pixel_in,
  // halftone output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [edh_pkg::PIX_W-1:0]       pixel_out,
  output logic                            frame_end,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [edh_pkg::ADDR_W-1:0]      paddr,
  input  logic [edh_pkg::DATA_W-1:0]      pwdata,
  output logic [edh_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int COL_W = edh_pkg::COL_W;
  localparam int ROW_W = edh_pkg::ROW_W;
  localparam int WID_W = edh_pkg::WID_W;
  localparam int HGT_W = edh_pkg::HGT_W;
  localparam int PIX_W = edh_pkg::PIX_W;
  localparam int ERR_W = edh_pkg::ERR_W;
  localparam int SUM_W = edh_pkg::SUM_W;
  localparam int T_W   = edh_pkg::T_W;
  localparam int FB    = edh_pkg::FRAC_BITS;

  localparam logic signed [SUM_W-1:0] K_ABOVE = SUM_W'(edh_pkg::W_ABOVE);
  localparam logic signed [SUM_W-1:0] K_DIAG  = SUM_W'(edh_pkg::W_DIAG);
  localparam logic signed [SUM_W-1:0] K_LEFT  = SUM_W'(edh_pkg::W_LEFT);
  localparam logic signed [SUM_W-1:0] K_ROUND = SUM_W'(edh_pkg::W_ROUND);
  localparam logic signed [T_W-1:0]   E_HI    = T_W'(edh_pkg::ERR_MAX);
  localparam logic signed [T_W-1:0]   E_LO    = T_W'(edh_pkg::ERR_MIN);
  localparam logic [WID_W-1:0]        W_MAXV  = WID_W'(edh_pkg::MAX_WIDTH);
  localparam logic [HGT_W-1:0]        H_MAXV  = HGT_W'(edh_pkg::MAX_HEIGHT);

  // configuration registers
  logic [PIX_W-1:0] threshold_level;
  logic [PIX_W-1:0] one_value;
  logic [PIX_W-1:0] zero_value;
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;

  edh_pkg::reg_idx_t reg_idx;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = edh_pkg::reg_idx_t'(paddr[edh_pkg::ADDR_W-1:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= edh_pkg::THRESHOLD_RST;
      one_value       <= edh_pkg::ONE_VALUE_RST;
      zero_value      <= edh_pkg::ZERO_VALUE_RST;
      image_width     <= edh_pkg::WIDTH_RST;
      image_height    <= edh_pkg::HEIGHT_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        edh_pkg::REG_THRESHOLD:  threshold_level <= pwdata[PIX_W-1:0];
        edh_pkg::REG_ONE_VALUE:  one_value       <= pwdata[PIX_W-1:0];
        edh_pkg::REG_ZERO_VALUE: zero_value      <= pwdata[PIX_W-1:0];
        edh_pkg::REG_WIDTH:      image_width     <= pwdata[WID_W-1:0];
        edh_pkg::REG_HEIGHT:     image_height    <= pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      edh_pkg::REG_THRESHOLD:  prdata = edh_pkg::DATA_W'(threshold_level);
      edh_pkg::REG_ONE_VALUE:  prdata = edh_pkg::DATA_W'(one_value);
      edh_pkg::REG_ZERO_VALUE: prdata = edh_pkg::DATA_W'(zero_value);
      edh_pkg::REG_WIDTH:      prdata = edh_pkg::DATA_W'(image_width);
      edh_pkg::REG_HEIGHT:     prdata = edh_pkg::DATA_W'(image_height);
      default:                 prdata = '0;
    endcase
  end

  // input side: raster counters and line memory read
  logic             in_accept;
  logic             s1_valid;
  logic             s1_fire;
  logic [WID_W-1:0] width_c;
  logic [HGT_W-1:0] height_c;
  logic             last_col;
  logic             last_row;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  always_comb begin
    width_c = image_width;
    if (image_width == '0) width_c = WID_W'(1);
    else if (image_width > W_MAXV) width_c = W_MAXV;
    height_c = image_height;
    if (image_height == '0) height_c = HGT_W'(1);
    else if (image_height > H_MAXV) height_c = H_MAXV;
  end

  assign last_col  = (WID_W'(column_count) + WID_W'(1)) >= width_c;
  assign last_row  = (HGT_W'(row_count) + HGT_W'(1)) >= height_c;
  assign in_ready  = !s1_valid || s1_fire;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // stage 1 registers
  logic [PIX_W-1:0] s1_pix;
  logic [COL_W-1:0] s1_col;
  logic             s1_row0;
  logic             s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix  <= pixel_in;
      s1_col  <= column_count;
      s1_row0 <= (row_count == '0);
      s1_last <= last_col && last_row;
    end
  end

  // line memory of row-above errors
  logic signed [ERR_W-1:0] error_line [edh_pkg::MAX_WIDTH];
  logic signed [ERR_W-1:0] line_rd;
  logic signed [ERR_W-1:0] byp_data;
  logic                    byp_hit;
  logic signed [ERR_W-1:0] e_sat;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      error_line[s1_col] <= e_sat;
    end
    if (in_accept) begin
      line_rd <= error_line[column_count];
    end
  end

  // same-column write in the accept cycle (one-pixel rows) is forwarded
  always_ff @(posedge clk) begin
    if (in_accept) begin
      byp_hit  <= s1_fire && (s1_col == column_count);
      byp_data <= e_sat;
    end
  end

  // error feedback state
  logic signed [ERR_W-1:0] left_error;
  logic signed [ERR_W-1:0] left2_error;
  logic signed [ERR_W-1:0] above_win0;
  logic signed [ERR_W-1:0] above_win1;

  // error sum, threshold and new error
  logic                    col0;
  logic signed [ERR_W-1:0] a;
  logic signed [ERR_W-1:0] al;
  logic signed [ERR_W-1:0] al2;
  logic signed [ERR_W-1:0] l;
  logic signed [SUM_W-1:0] total;
  logic signed [T_W-1:0]   ep;
  logic signed [T_W-1:0]   t;
  logic signed [T_W-1:0]   thr;
  logic signed [T_W-1:0]   thr2;
  logic signed [T_W-1:0]   e;
  logic                    one;

  assign col0 = (s1_col == '0);

  always_comb begin
    a = '0;
    if (!s1_row0) a = byp_hit ? byp_data : line_rd;
    l = col0 ? '0 : left_error;
    if (s1_row0) begin
      al  = col0 ? '0 : left_error;
      al2 = col0 ? '0 : left2_error;
    end else begin
      al  = col0 ? a : above_win0;
      al2 = col0 ? a : above_win1;
    end
    total = SUM_W'(a) * K_ABOVE + (SUM_W'(al) + SUM_W'(al2)) * K_DIAG
          + SUM_W'(l) * K_LEFT + K_ROUND;
    ep    = T_W'(total >>> edh_pkg::W_SHIFT);
    t     = T_W'($signed({1'b0, s1_pix, FB'(0)})) + ep;
    thr   = T_W'($signed({1'b0, threshold_level, FB'(0)}));
    thr2  = T_W'($signed({1'b0, threshold_level, (FB + 1)'(0)}));
    one   = t > thr;
    e     = one ? t - thr2 : t;
    if (e > E_HI) e_sat = E_HI[ERR_W-1:0];
    else if (e < E_LO) e_sat = E_LO[ERR_W-1:0];
    else e_sat = e[ERR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_error  <= '0;
      left2_error <= '0;
      above_win0  <= '0;
      above_win1  <= '0;
    end else if (s1_fire) begin
      left_error  <= e_sat;
      left2_error <= col0 ? e_sat : left_error;
      if (!s1_row0) begin
        above_win1 <= col0 ? a : above_win0;
        above_win0 <= a;
      end
    end
  end

  // result register
  assign s1_fire = s1_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pixel_out <= one ? one_value : zero_value;
      frame_end <= s1_last;
    end
  end

  // checks
  `ASSERT_PROP(a_stage_holds, clk, rst, s1_valid && !s1_fire |=> s1_valid)
  `ASSERT_NEVER(a_ready_low_only_full, clk, rst, !in_ready && !(s1_valid && out_valid))
  `ASSERT_PROP(a_col_wraps, clk, rst, in_accept && last_col |=> column_count == '0)

endmodule
